[sv/itra_pkg.sv]
// Shared types, constants and the digit-to-character map for the radix converter.
package itra_pkg;

  localparam int VALUE_BITS_DEF = 32;

  localparam int RADIX_W = 6;
  localparam int BUF_W   = 8;
  localparam int CFG_W   = 8;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 6;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RST = RADIX_W'(10);
  localparam logic [BUF_W-1:0]   BUF_MIN   = BUF_W'(2);
  localparam logic [BUF_W-1:0]   BUF_RST   = BUF_W'(10);

  localparam logic [DIGIT_W-1:0] DEC_DIGITS   = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_NONE    = 8'h00;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 8'h61;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_RADIX   = 1'b0,
    REG_BUF_LEN = 1'b1
  } reg_idx_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_RADIX = 2'd2,
    ST_FIT   = 2'd3
  } status_e;

  // Classification of one request, carried through the queue
  typedef struct packed {
    logic    neg;
    status_e status;
  } ctl_t;

  // Map a digit value below 36 to '0'-'9' or 'a'-'z'
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DEC_DIGITS) begin
      return CHAR_ZERO + dx;
    end else begin
      return CHAR_LOWER_A + dx - CHAR_W'(DEC_DIGITS);
    end
  endfunction

endpackage

[sv/integer_to_radix_ascii.sv]
// A request is registered into the queue, then converted one magnitude bit per cycle
// through the digit carry adder; the digits are aligned and checked for fit, then the sign
// and digit characters are emitted, held on output stalls; errors emit one character.
// Throughput: the back end holds one request; a two-entry queue takes new requests meanwhile.
// Reset: radix 10, buffer length 10, queue empty, no result pending.
module integer_to_radix_ascii #(
  parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_addr_i,
  input  logic [itra_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic [VALUE_BITS-1:0]       value_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output logic [itra_pkg::CHAR_W-1:0] character_o,
  output logic                        last_o,
  output logic [1:0]                  status_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i
);

  localparam int QW = VALUE_BITS + $bits(itra_pkg::ctl_t);

  logic [itra_pkg::RADIX_W-1:0] radix_q;
  logic [itra_pkg::BUF_W-1:0]   buf_len_q;
  logic                         q_push, q_full, q_pop, q_empty;
  logic [VALUE_BITS-1:0]        f_mag, b_mag;
  itra_pkg::ctl_t               f_ctl, b_ctl;
  logic [QW-1:0]                q_rdata;
  itra_pkg::status_e            b_status;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q   <= itra_pkg::RADIX_RST;
      buf_len_q <= itra_pkg::BUF_RST;
    end else if (cfg_we_i) begin
      unique case (itra_pkg::reg_idx_e'(cfg_addr_i))
        itra_pkg::REG_RADIX:   radix_q   <= cfg_wdata_i[itra_pkg::RADIX_W-1:0];
        itra_pkg::REG_BUF_LEN: buf_len_q <= cfg_wdata_i[itra_pkg::BUF_W-1:0];
        default: begin
          radix_q <= radix_q;
        end
      endcase
    end
  end

  itra_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .value_i   (value_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .radix_i   (radix_q),
    .buf_len_i (buf_len_q),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_mag_o   (f_mag),
    .q_ctl_o   (f_ctl)
  );

  itra_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i({f_ctl, f_mag}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  assign b_mag = q_rdata[VALUE_BITS-1:0];
  assign b_ctl = itra_pkg::ctl_t'(q_rdata[QW-1:VALUE_BITS]);

  itra_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .radix_i    (radix_q),
    .buf_len_i  (buf_len_q),
    .q_valid_i  (!q_empty),
    .q_mag_i    (b_mag),
    .q_ctl_i    (b_ctl),
    .q_pop_o    (q_pop),
    .character_o(character_o),
    .last_o     (last_o),
    .status_o   (b_status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

  assign status_o = b_status;

endmodule

[sv/itra_front.sv]
// Front end: accepts requests, forms sign and magnitude, flags setup errors.
module itra_front #(
  parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS-1:0]        value_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [itra_pkg::RADIX_W-1:0] radix_i,
  input  logic [itra_pkg::BUF_W-1:0]   buf_len_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output logic [VALUE_BITS-1:0]        q_mag_o,
  output itra_pkg::ctl_t               q_ctl_o
);

  logic neg;

  // Take a request whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Magnitude as unsigned, so the most negative value is exact
  assign neg     = value_i[VALUE_BITS-1];
  assign q_mag_o = neg ? (~value_i + VALUE_BITS'(1)) : value_i;

  // Classify: short buffer wins over bad radix
  always_comb begin
    q_ctl_o.neg = neg;
    if (buf_len_i < itra_pkg::BUF_MIN) begin
      q_ctl_o.status = itra_pkg::ST_SHORT;
    end else if (radix_i < itra_pkg::RADIX_MIN || radix_i > itra_pkg::RADIX_MAX) begin
      q_ctl_o.status = itra_pkg::ST_RADIX;
    end else begin
      q_ctl_o.status = itra_pkg::ST_OK;
    end
  end

endmodule

[sv/itra_queue.sv]
// Two-entry queue between the front end and the conversion engine.
module itra_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0)
    else $error("queue popped while empty");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q != 2'd2)
    else $error("queue pushed while full");

endmodule

[sv/itra_back.sv]
// Back end: binary to radix conversion, digit alignment, fit check and emission.
module itra_back #(
  parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [itra_pkg::RADIX_W-1:0] radix_i,
  input  logic [itra_pkg::BUF_W-1:0]   buf_len_i,
  input  logic                         q_valid_i,
  input  logic [VALUE_BITS-1:0]        q_mag_i,
  input  itra_pkg::ctl_t               q_ctl_i,
  output logic                         q_pop_o,
  output logic [itra_pkg::CHAR_W-1:0]  character_o,
  output logic                         last_o,
  output itra_pkg::status_e            status_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i
);

  localparam int ND    = VALUE_BITS;
  localparam int DW    = itra_pkg::DIGIT_W;
  localparam int NDW   = $clog2(ND + 1);
  localparam int STG_W = $clog2(NDW);
  localparam int CMP_W = (NDW + 1 > itra_pkg::BUF_W) ? NDW + 1 : itra_pkg::BUF_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_ALIGN = 3'd2;
  localparam logic [2:0] S_FIT   = 3'd3;
  localparam logic [2:0] S_ERR   = 3'd4;
  localparam logic [2:0] S_SIGN  = 3'd5;
  localparam logic [2:0] S_DIGIT = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic [ND-1:0]               mag_q, mag_d;
  logic                        neg_q, neg_d;
  itra_pkg::status_e           stat_q, stat_d;
  logic [ND*DW-1:0]            dig_q, dig_d;
  logic [NDW-1:0]              nd_q, nd_d;
  logic [NDW-1:0]              cnt_q, cnt_d;
  logic [STG_W-1:0]            stg_q, stg_d;
  logic                        out_valid_q, out_valid_d;
  logic [itra_pkg::CHAR_W-1:0] char_q, char_d;
  logic                        last_q, last_d;
  itra_pkg::status_e           ostat_q, ostat_d;

  logic                        out_free;
  logic [ND-1:0]               gen, prop;
  logic [ND:0]                 csum, cvec;
  logic [ND*DW-1:0]            dig_conv, dig_align;
  logic [NDW-1:0]              sh;
  logic                        no_fit;
  logic [DW-1:0]               dig_top;
  logic [DW:0]                 rad_x;

  assign out_free = !out_valid_q || out_ready_i;
  assign rad_x    = {1'b0, radix_i};

  // Per digit: doubling overflows the radix (generate) or does so only with a carry in
  always_comb begin
    logic [DW-1:0] d;
    for (int i = 0; i < ND; i++) begin
      d       = dig_q[i*DW +: DW];
      gen[i]  = {d, 1'b0} >= rad_x;
      prop[i] = {d, 1'b1} == rad_x;
    end
  end

  // Resolve the digit carries with one wide add, next magnitude bit enters at digit 0
  assign csum = {1'b0, gen} + {1'b0, gen | prop} + {{ND{1'b0}}, mag_q[ND-1]};
  assign cvec = csum ^ {1'b0, gen} ^ {1'b0, gen | prop};

  // Double every digit, add its carry in, subtract the radix where it carries out
  always_comb begin
    logic [DW-1:0] d;
    logic [DW:0]   nxt;
    for (int i = 0; i < ND; i++) begin
      d   = dig_q[i*DW +: DW];
      nxt = {d, 1'b0} + {{DW{1'b0}}, cvec[i]} - (cvec[i+1] ? rad_x : '0);
      dig_conv[i*DW +: DW] = nxt[DW-1:0];
    end
  end

  // Move the most significant digit to the top slot, one power of two per cycle
  assign sh        = NDW'(ND) - nd_q;
  assign dig_align = sh[stg_q] ? (dig_q << (DW << stg_q)) : dig_q;

  // Sign, digits and terminator must fit in the buffer
  assign no_fit  = (CMP_W'(nd_q) + CMP_W'(neg_q) + CMP_W'(1)) > CMP_W'(buf_len_i);
  assign dig_top = dig_q[ND*DW-1 -: DW];

  // Sequence one request
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    stat_d      = stat_q;
    dig_d       = dig_q;
    nd_d        = nd_q;
    cnt_d       = cnt_q;
    stg_d       = stg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    ostat_d     = ostat_q;
    q_pop_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          mag_d   = q_mag_i;
          neg_d   = q_ctl_i.neg;
          stat_d  = q_ctl_i.status;
          dig_d   = '0;
          nd_d    = NDW'(1);
          cnt_d   = NDW'(ND);
          stg_d   = '0;
          state_d = (q_ctl_i.status != itra_pkg::ST_OK) ? S_ERR : S_CONV;
        end
      end
      S_CONV: begin
        mag_d = mag_q << 1;
        dig_d = dig_conv;
        if (cvec[nd_q]) begin
          nd_d = nd_q + NDW'(1);
        end
        cnt_d = cnt_q - NDW'(1);
        if (cnt_q == NDW'(1)) begin
          state_d = S_ALIGN;
        end
      end
      S_ALIGN: begin
        dig_d = dig_align;
        stg_d = stg_q + STG_W'(1);
        if (stg_q == STG_W'(NDW - 1)) begin
          state_d = S_FIT;
        end
      end
      S_FIT: begin
        if (no_fit) begin
          stat_d  = itra_pkg::ST_FIT;
          state_d = S_ERR;
        end else begin
          state_d = neg_q ? S_SIGN : S_DIGIT;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = itra_pkg::CHAR_NONE;
          last_d      = 1'b1;
          ostat_d     = stat_q;
          state_d     = S_IDLE;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = itra_pkg::CHAR_MINUS;
          last_d      = 1'b0;
          ostat_d     = itra_pkg::ST_OK;
          state_d     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = itra_pkg::digit_char(dig_top);
          last_d      = (nd_q == NDW'(1));
          ostat_d     = itra_pkg::ST_OK;
          dig_d       = dig_q << DW;
          nd_d        = nd_q - NDW'(1);
          if (nd_q == NDW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      nd_q        <= '0;
      cnt_q       <= '0;
      stg_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      nd_q        <= nd_d;
      cnt_q       <= cnt_d;
      stg_q       <= stg_d;
    end
  end

  // Datapath and output holding register
  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    stat_q  <= stat_d;
    dig_q   <= dig_d;
    char_q  <= char_d;
    last_q  <= last_d;
    ostat_q <= ostat_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign status_o    = ostat_q;

  a_nd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE && state_q != S_ERR |-> nd_q != '0 && nd_q <= NDW'(ND))
    else $error("digit count out of range");
  a_digit_lt_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIGIT |-> dig_top < radix_i)
    else $error("emitted digit not below radix");
  a_err_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ERR |-> stat_q != itra_pkg::ST_OK)
    else $error("error result without error status");

endmodule

[dv/integer_to_radix_ascii_test.sv]
// Testbench for integer_to_radix_ascii: directed table, then random requests under flow control.
`timescale 1ns / 100ps

module integer_to_radix_ascii_test;

  localparam int N_DIRECTED = 25;
  localparam int N_PHASES   = 6;
  localparam int PHASE_REQS = 26;

  // One expected output character
  typedef struct packed {
    logic [itra_pkg::CHAR_W-1:0] character;
    logic                        last;
    itra_pkg::status_e           status;
  } char_result_t;

  // One row of the directed table; text is right-aligned, zero bytes are padding
  typedef struct packed {
    logic [7:0]        radix_wr;
    logic [7:0]        buf_wr;
    logic [31:0]       value;
    logic              typed;
    logic [127:0]      text;
    itra_pkg::status_e status;
  } dir_row_t;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE
  } rx_mode_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [0:0]                  cfg_addr_i;
  logic [itra_pkg::CFG_W-1:0]  cfg_wdata_i;
  logic [31:0]                 value_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [itra_pkg::CHAR_W-1:0] character_o;
  logic                        last_o;
  logic [1:0]                  status_o;
  logic                        out_valid_o;
  logic                        out_ready_i;

  char_result_t expected_chars[$];
  int           mismatches = 0;
  int           burst_left = 0;
  bit           long_hold_req = 1'b0;

  // Predictor copy of the configuration and of the raw data last written
  logic [itra_pkg::RADIX_W-1:0] cur_radix   = itra_pkg::RADIX_RST;
  logic [itra_pkg::BUF_W-1:0]   cur_buf_len = itra_pkg::BUF_RST;
  logic [7:0]                   radix_wr_q  = 8'd10;
  logic [7:0]                   buf_wr_q    = 8'd10;

  // Directed table: reset setting first, then extremes and every error path
  dir_row_t dir_rows [N_DIRECTED] = '{
    '{8'd10,  8'd10,  32'd0,           1'b1, "0",         itra_pkg::ST_OK},
    '{8'd10,  8'd10,  32'd123456789,   1'b1, "123456789", itra_pkg::ST_OK},
    '{8'd10,  8'd10,  -32'sd123456789, 1'b1, "",          itra_pkg::ST_FIT},
    '{8'd10,  8'd10,  -32'sd12345678,  1'b1, "-12345678", itra_pkg::ST_OK},
    '{8'd10,  8'd10,  32'h7fff_ffff,   1'b1, "",          itra_pkg::ST_FIT},
    '{8'd2,   8'd255, 32'h8000_0000,   1'b0, "",          itra_pkg::ST_OK},
    '{8'd2,   8'd255, 32'hffff_ffff,   1'b1, "-1",        itra_pkg::ST_OK},
    '{8'd2,   8'd255, 32'h7fff_ffff,   1'b0, "",          itra_pkg::ST_OK},
    '{8'd36,  8'd255, 32'h7fff_ffff,   1'b0, "",          itra_pkg::ST_OK},
    '{8'd36,  8'd255, 32'h8000_0000,   1'b0, "",          itra_pkg::ST_OK},
    '{8'd36,  8'd255, 32'd35,          1'b1, "z",         itra_pkg::ST_OK},
    '{8'd16,  8'd255, 32'd255,         1'b1, "ff",        itra_pkg::ST_OK},
    '{8'd16,  8'd255, -32'sd43981,     1'b1, "-abcd",     itra_pkg::ST_OK},
    '{8'd0,   8'd255, 32'd5,           1'b1, "",          itra_pkg::ST_RADIX},
    '{8'd1,   8'd255, 32'd5,           1'b1, "",          itra_pkg::ST_RADIX},
    '{8'd37,  8'd255, 32'd5,           1'b1, "",          itra_pkg::ST_RADIX},
    '{8'hc8,  8'd255, 32'd8,           1'b1, "10",        itra_pkg::ST_OK},
    '{8'd63,  8'd255, 32'd0,           1'b1, "",          itra_pkg::ST_RADIX},
    '{8'd63,  8'd0,   32'd0,           1'b1, "",          itra_pkg::ST_SHORT},
    '{8'd10,  8'd1,   32'd7,           1'b1, "",          itra_pkg::ST_SHORT},
    '{8'd10,  8'd2,   32'd7,           1'b1, "7",         itra_pkg::ST_OK},
    '{8'd10,  8'd2,   -32'sd7,         1'b1, "",          itra_pkg::ST_FIT},
    '{8'd10,  8'd2,   32'd10,          1'b1, "",          itra_pkg::ST_FIT},
    '{8'd10,  8'd12,  32'h8000_0000,   1'b0, "",          itra_pkg::ST_OK},
    '{8'd10,  8'd11,  32'h8000_0000,   1'b1, "",          itra_pkg::ST_FIT}
  };

  integer_to_radix_ascii #(
    .VALUE_BITS(32)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (value_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .character_o (character_o),
    .last_o      (last_o),
    .status_o    (status_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic void push_char(input logic [itra_pkg::CHAR_W-1:0] ch, input logic lst,
                                    input itra_pkg::status_e st);
    char_result_t r;
    r.character = ch;
    r.last      = lst;
    r.status    = st;
    expected_chars.push_back(r);
  endfunction

  // Work out the characters one value turns into under the current setting
  function automatic void radix_text(input logic [31:0] val);
    logic [5:0]  digs [32];
    logic        neg;
    logic [31:0] mag;
    logic [31:0] base;
    logic [5:0]  d;
    int          nd;
    int          need;
    neg  = val[31];
    mag  = neg ? (~val + 32'd1) : val;
    base = 32'(cur_radix);
    nd   = 0;
    if (cur_buf_len < itra_pkg::BUF_MIN) begin
      push_char(itra_pkg::CHAR_NONE, 1'b1, itra_pkg::ST_SHORT);
      return;
    end
    if (cur_radix < itra_pkg::RADIX_MIN || cur_radix > itra_pkg::RADIX_MAX) begin
      push_char(itra_pkg::CHAR_NONE, 1'b1, itra_pkg::ST_RADIX);
      return;
    end
    do begin
      digs[nd] = 6'(mag % base);
      nd++;
      mag = mag / base;
    end while (mag != 32'd0);
    need = nd + (neg ? 1 : 0) + 1;
    if (need > int'(cur_buf_len)) begin
      push_char(itra_pkg::CHAR_NONE, 1'b1, itra_pkg::ST_FIT);
      return;
    end
    if (neg) push_char(itra_pkg::CHAR_MINUS, 1'b0, itra_pkg::ST_OK);
    for (int i = nd - 1; i >= 0; i--) begin
      d = digs[i];
      push_char((d < 6'd10) ? itra_pkg::CHAR_ZERO + 8'(d)
                            : itra_pkg::CHAR_LOWER_A + 8'(d) - 8'd10,
                i == 0, itra_pkg::ST_OK);
    end
  endfunction

  // Queue the characters typed into a directed row
  function automatic void expect_typed(input dir_row_t row);
    if (row.status != itra_pkg::ST_OK) begin
      push_char(itra_pkg::CHAR_NONE, 1'b1, row.status);
    end else begin
      for (int k = 15; k >= 0; k--) begin
        if (row.text[k*8 +: 8] != 8'h00) begin
          push_char(row.text[k*8 +: 8], k == 0, itra_pkg::ST_OK);
        end
      end
    end
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] mag;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'hffff_ffff;
          3: return 32'h7fff_ffff;
          default: return 32'h8000_0000;
        endcase
      end
      default: begin
        mag = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  // Hold the request until it is taken; returns at the accepting edge
  task automatic offer_value(input logic [31:0] val);
    in_valid_i <= 1'b1;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Keep offering within a burst, otherwise drop valid for a random gap
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 90 : 6);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 20 : 4);
    end
  endtask

  // Drain all outstanding characters, then write both registers
  task automatic apply_config(input logic [7:0] radix_wr, input logic [7:0] buf_wr);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_chars.size() != 0);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= itra_pkg::REG_RADIX;
    cfg_wdata_i <= radix_wr;
    @(posedge clk_i);
    cfg_addr_i  <= itra_pkg::REG_BUF_LEN;
    cfg_wdata_i <= buf_wr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_radix   = radix_wr[itra_pkg::RADIX_W-1:0];
    cur_buf_len = buf_wr;
    radix_wr_q  = radix_wr;
    buf_wr_q    = buf_wr;
    burst_left  = 0;
  endtask

  // Request side: reset, directed table, random phases, final drain
  initial begin
    logic [7:0]  radix_wr;
    logic [7:0]  buf_wr;
    logic [31:0] val;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_addr_i  <= itra_pkg::REG_RADIX;
    cfg_wdata_i <= '0;
    value_i     <= '0;
    in_valid_i  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].radix_wr != radix_wr_q || dir_rows[r].buf_wr != buf_wr_q) begin
        apply_config(dir_rows[r].radix_wr, dir_rows[r].buf_wr);
      end
      offer_value(dir_rows[r].value);
      if (dir_rows[r].typed) expect_typed(dir_rows[r]);
      else radix_text(dir_rows[r].value);
      pace_sender();
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin radix_wr = 8'd10; buf_wr = 8'd12; end
        1: begin radix_wr = 8'd2;  buf_wr = 8'd34; end
        2: begin radix_wr = 8'd16; buf_wr = 8'd10; end
        default: begin
          radix_wr = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                   : {2'($urandom), 6'($urandom_range(2, 36))};
          buf_wr   = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                   : 8'($urandom_range(2, 40));
        end
      endcase
      apply_config(radix_wr, buf_wr);
      // Fill the block while the result side holds off
      if (p == 0) begin
        long_hold_req = 1'b1;
        burst_left    = 12;
      end
      for (int n = 0; n < PHASE_REQS; n++) begin
        val = rand_value();
        offer_value(val);
        radix_text(val);
        pace_sender();
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_chars.size() != 0);
    repeat (120) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("integer_to_radix_ascii test passed");
    end else begin
      $display("integer_to_radix_ascii test failed");
    end
    $finish;
  end

  // Result side: check each taken character, then pick the next ready
  initial begin
    char_result_t exp_c;
    rx_mode_e     mode;
    int           mode_left;
    int           hold_left;
    mode        = RX_STREAM;
    mode_left   = 0;
    hold_left   = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character 0x%02h (last %0b, status %0d)",
                 character_o, last_o, status_o);
          mismatches++;
        end else begin
          exp_c = expected_chars.pop_front();
          if (character_o !== exp_c.character) begin
            $error("character: expected 0x%02h, got 0x%02h", exp_c.character, character_o);
            mismatches++;
          end
          if (last_o !== exp_c.last) begin
            $error("last: expected %0b, got %0b", exp_c.last, last_o);
            mismatches++;
          end
          if (status_o !== exp_c.status) begin
            $error("status: expected %0d, got %0d", exp_c.status, status_o);
            mismatches++;
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          RX_STREAM: out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          default:   out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Guard against a hung handshake
  initial begin
    #10_000_000;
    $display("integer_to_radix_ascii test failed");
    $finish;
  end

endmodule
